// ===== design/ucp_pkg.sv =====
// ----------------------------------------------------------------------------
// ucp_pkg: shared types and constants of the unit cross product block.
// Holds the request and result structs and the default output format.
// ----------------------------------------------------------------------------
package ucp_pkg;

	// Default number of fraction bits of the result components.
	localparam int FRAC_BITS_DEF = 14;

	typedef struct packed {
		logic signed [15:0] a_x;
		logic signed [15:0] a_y;
		logic signed [15:0] a_z;
		logic signed [15:0] b_x;
		logic signed [15:0] b_y;
		logic signed [15:0] b_z;
	} vec_t;

	typedef struct packed {
		logic signed [15:0] u_x;
		logic signed [15:0] u_y;
		logic signed [15:0] u_z;
		logic               degenerate;
	} norm_t;

endpackage

// ===== design/ucp_front.sv =====
// ----------------------------------------------------------------------------
// ucp_front: cross product, magnitudes, squares and the squared length.
// Four register stages; produces the sum of squares and the scaled targets.
// ----------------------------------------------------------------------------
module ucp_front #(
	parameter int FRAC_BITS = ucp_pkg::FRAC_BITS_DEF,
	localparam int WW = 2 * FRAC_BITS + 69
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  ucp_pkg::vec_t        vec,
	output logic                 v_out,
	output logic [63:0]          s_out,
	output logic [2:0][WW-1:0]   t_out,
	output logic [2:0]           sgn_out
);
	import ucp_pkg::*;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0]       prod_s1 [6];
	logic [2:0][31:0]         mag_s2;
	logic [2:0]               sgn_s2, sgn_s3, sgn_s4;
	logic [2:0][63:0]         sq_s3;
	logic [63:0]              s_s4;
	logic [2:0][WW-1:0]       t_s4;
	logic signed [32:0]       diff [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = 33'($signed(prod_s1[2*i])) - 33'($signed(prod_s1[2*i+1]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= vec.a_y * vec.b_z;
			prod_s1[1] <= vec.b_y * vec.a_z;
			prod_s1[2] <= vec.b_x * vec.a_z;
			prod_s1[3] <= vec.a_x * vec.b_z;
			prod_s1[4] <= vec.a_x * vec.b_y;
			prod_s1[5] <= vec.b_x * vec.a_y;
			for (int i = 0; i < 3; i++) begin
				sgn_s2[i] <= diff[i][32];
				mag_s2[i] <= diff[i][32] ? 32'(-diff[i]) : 32'(diff[i]);
				sq_s3[i]  <= 64'(mag_s2[i]) * 64'(mag_s2[i]);
				t_s4[i]   <= WW'(sq_s3[i]) << (2 * FRAC_BITS + 2);
			end
			sgn_s3 <= sgn_s2;
			sgn_s4 <= sgn_s3;
			s_s4   <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		end
	end

	assign v_out   = v_s4;
	assign s_out   = s_s4;
	assign t_out   = t_s4;
	assign sgn_out = sgn_s4;

endmodule

// ===== design/ucp_step.sv =====
// ----------------------------------------------------------------------------
// ucp_step: one bit of the rounded ratio search for all three components.
// Tries to set one result bit using running sums, with adds and shifts only.
// ----------------------------------------------------------------------------
module ucp_step #(
	parameter int FRAC_BITS = ucp_pkg::FRAC_BITS_DEF,
	parameter int BIT = 0,
	localparam int WW = 2 * FRAC_BITS + 69
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  logic [63:0]              s_in,
	input  logic [2:0][WW-1:0]       t_in,
	input  logic [2:0][WW-1:0]       p_in,
	input  logic [2:0][WW-1:0]       r_in,
	input  logic [2:0][FRAC_BITS:0]  q_in,
	input  logic [2:0]               sgn_in,
	output logic                     v_out,
	output logic [63:0]              s_out,
	output logic [2:0][WW-1:0]       t_out,
	output logic [2:0][WW-1:0]       p_out,
	output logic [2:0][WW-1:0]       r_out,
	output logic [2:0][FRAC_BITS:0]  q_out,
	output logic [2:0]               sgn_out
);
	import ucp_pkg::*;

	logic                     v_s1;
	logic [63:0]              s_s1;
	logic [2:0][WW-1:0]       t_s1, p_s1, r_s1;
	logic [2:0][FRAC_BITS:0]  q_s1;
	logic [2:0]               sgn_s1;
	logic [WW-1:0]            s_w;
	logic [2:0][WW-1:0]       cand;
	logic [2:0]               take;

	// P tracks (2q-1)^2*s and R tracks (2q-1)*s for the bits kept so far.
	assign s_w = WW'(s_in);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cand[i] = p_in[i] + (r_in[i] << (BIT + 2)) + (s_w << (2 * BIT + 2));
			take[i] = (cand[i] <= t_in[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= s_in;
			t_s1   <= t_in;
			sgn_s1 <= sgn_in;
			for (int i = 0; i < 3; i++) begin
				if (take[i]) begin
					p_s1[i] <= cand[i];
					r_s1[i] <= r_in[i] + (s_w << (BIT + 1));
					q_s1[i] <= q_in[i] | ((FRAC_BITS + 1)'(1) << BIT);
				end else begin
					p_s1[i] <= p_in[i];
					r_s1[i] <= r_in[i];
					q_s1[i] <= q_in[i];
				end
			end
		end
	end

	assign v_out   = v_s1;
	assign s_out   = s_s1;
	assign t_out   = t_s1;
	assign p_out   = p_s1;
	assign r_out   = r_s1;
	assign q_out   = q_s1;
	assign sgn_out = sgn_s1;

endmodule

// ===== design/unit_cross_product_3d.sv =====
// ----------------------------------------------------------------------------
// unit_cross_product_3d: unit normal of two 3D vectors in fixed point.
// The block takes a request of two vectors with signed Q1.14 components and
// returns the cross product scaled to unit length, each component in
// Q(FRAC_BITS), rounded to nearest with ties away from zero and saturated to
// 16 bits. When the vectors are parallel or zero the result is the zero
// vector with degenerate set. Unless stalled, the block takes one request
// per clock cycle and returns one result per cycle. The pipeline depth is
// set by the exact rounded ratio search, which resolves one result bit per
// pipeline stage for all three components at once. A stall on the result
// side freezes the whole pipeline and is passed straight to the request side.
// ----------------------------------------------------------------------------
module unit_cross_product_3d #(
	parameter int FRAC_BITS = ucp_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vec_valid,
	output logic            vec_stall,
	input  ucp_pkg::vec_t   vec,
	output logic            norm_valid,
	input  logic            norm_stall,
	output ucp_pkg::norm_t  norm
);
	import ucp_pkg::*;

	localparam int WW = 2 * FRAC_BITS + 69;
	localparam int NS = FRAC_BITS + 2;
	localparam int EW = FRAC_BITS + 18;

	// The pipeline moves whenever the result register is free or being taken.
	logic en;
	assign en        = !(norm_valid && norm_stall);
	assign vec_stall = !en;

	logic                     f_v;
	logic [63:0]              f_s;
	logic [2:0][WW-1:0]       f_t;
	logic [2:0]               f_sgn;

	ucp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (vec_valid),
		.vec     (vec),
		.v_out   (f_v),
		.s_out   (f_s),
		.t_out   (f_t),
		.sgn_out (f_sgn)
	);

	// Chain of search stages; entry zero starts every lane at q = 0, where
	// (2q-1) = -1, so P = s and R = -s.
	logic                     ch_v   [NS];
	logic [63:0]              ch_s   [NS];
	logic [2:0][WW-1:0]       ch_t   [NS];
	logic [2:0][WW-1:0]       ch_p   [NS];
	logic [2:0][WW-1:0]       ch_r   [NS];
	logic [2:0][FRAC_BITS:0]  ch_q   [NS];
	logic [2:0]               ch_sgn [NS];

	always_comb begin
		ch_v[0]   = f_v;
		ch_s[0]   = f_s;
		ch_t[0]   = f_t;
		ch_sgn[0] = f_sgn;
		for (int i = 0; i < 3; i++) begin
			ch_p[0][i] = WW'(f_s);
			ch_r[0][i] = -WW'(f_s);
			ch_q[0][i] = '0;
		end
	end

	// The most significant result bit is resolved first.
	for (genvar j = 0; j < NS - 1; j++) begin : g_step
		ucp_step #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - j)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (ch_v[j]),
			.s_in    (ch_s[j]),
			.t_in    (ch_t[j]),
			.p_in    (ch_p[j]),
			.r_in    (ch_r[j]),
			.q_in    (ch_q[j]),
			.sgn_in  (ch_sgn[j]),
			.v_out   (ch_v[j+1]),
			.s_out   (ch_s[j+1]),
			.t_out   (ch_t[j+1]),
			.p_out   (ch_p[j+1]),
			.r_out   (ch_r[j+1]),
			.q_out   (ch_q[j+1]),
			.sgn_out (ch_sgn[j+1])
		);
	end

	// Sign, saturation and the degenerate case go into the result register.
	logic [EW-1:0]      q_ext [3];
	logic signed [15:0] comp  [3];
	logic               deg;

	always_comb begin
		deg = (ch_s[NS-1] == 64'd0);
		for (int i = 0; i < 3; i++) begin
			q_ext[i] = EW'(ch_q[NS-1][i]);
			if (deg) begin
				comp[i] = '0;
			end else if (ch_sgn[NS-1][i]) begin
				comp[i] = (q_ext[i] > EW'(32768)) ? 16'sh8000 : 16'(-q_ext[i]);
			end else begin
				comp[i] = (q_ext[i] > EW'(32767)) ? 16'sh7fff : 16'(q_ext[i]);
			end
		end
	end

	logic  norm_valid_q;
	norm_t norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_valid_q <= 1'b0;
		end else if (en) begin
			norm_valid_q <= ch_v[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_q.u_x        <= comp[0];
			norm_q.u_y        <= comp[1];
			norm_q.u_z        <= comp[2];
			norm_q.degenerate <= deg;
		end
	end

	assign norm_valid = norm_valid_q;
	assign norm       = norm_q;

	// A degenerate result carries the zero vector.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && norm.degenerate |->
			norm.u_x == 16'sd0 && norm.u_y == 16'sd0 && norm.u_z == 16'sd0)
		else $error("degenerate result with nonzero components");

	// A regular result always has a nonzero largest component.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && !norm.degenerate |->
			norm.u_x != 16'sd0 || norm.u_y != 16'sd0 || norm.u_z != 16'sd0)
		else $error("regular result is the zero vector");

	// Back pressure on requests only comes from a held result.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		vec_stall |-> norm_valid && norm_stall)
		else $error("request stalled without a held result");

endmodule
